// File: hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types for the sliding window median filter
// Command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic accept;     // take the input request, write the ring
        logic cfg_wr;     // take a window size write
        logic ins_rd;     // read sorted entry below the insertion index
        logic ins_shift;  // move the read entry up one slot
        logic ins_put;    // place the new sample at the insertion index
        logic ins_done;   // count the new sample
        logic med_rd;     // read median entry and oldest ring entry
        logic med_cap;    // capture median and oldest sample
        logic out_load;   // load the output register
        logic rem_rd;     // read sorted entry at the removal index
        logic rem_cmp;    // compare or shift down during removal
        logic rem_done;   // finish removal
    } t_cmd;

    typedef struct packed {
        logic idx_zero;   // insertion index reached the bottom
        logic gt;         // read entry is greater than the new sample
        logic full;       // window holds window_size samples after insertion
        logic rem_end;    // removal scan covered every held entry
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

// File: hw/rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: generic simple dual port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/swm_dp.sv
// ----------------------------------------------------------------------------
// swm_dp: datapath of the sliding window median filter
// Ring and sorted memory addressing, counters, comparators, output register.
// ----------------------------------------------------------------------------
module swm_dp
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1,
    localparam int CW = $clog2(WINDOW_MAX + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_start_new,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_median,
    output logic                o_srt_we,
    output logic [AW-1:0]       o_srt_waddr,
    output logic [SAMPLE_W-1:0] o_srt_wdata,
    output logic [AW-1:0]       o_srt_raddr,
    input  logic [SAMPLE_W-1:0] i_srt_rdata,
    output logic                o_ring_we,
    output logic [AW-1:0]       o_ring_waddr,
    output logic [SAMPLE_W-1:0] o_ring_wdata,
    output logic [AW-1:0]       o_ring_raddr,
    input  logic [SAMPLE_W-1:0] i_ring_rdata
);

    localparam int SW = CW + 1;

    logic [CW-1:0]       r_win;
    logic [CW-1:0]       r_fill;
    logic [AW-1:0]       r_rp;
    logic [CW-1:0]       r_idx;
    logic                r_found;
    t_sample             r_x;
    logic [SAMPLE_W-1:0] r_med;
    logic [SAMPLE_W-1:0] r_old;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_median;

    logic [CW-1:0]       n_win;
    logic [AW-1:0]       wr_slot;
    logic [AW-1:0]       n_rp;
    logic [CW-1:0]       fill_inc;
    logic [CW-1:0]       idx_dec;
    logic [CW-1:0]       med_idx;
    logic [SW-1:0]       old_sum;
    logic [SW-1:0]       old_idx;
    logic                rem_hit;

    // Window size zero acts as one, sizes above the memory depth saturate.
    always_comb begin
        if (i_cfg_data == '0) begin
            n_win = CW'(1);
        end else if (int'(i_cfg_data) > WINDOW_MAX) begin
            n_win = CW'(WINDOW_MAX);
        end else begin
            n_win = CW'(i_cfg_data);
        end
    end

    assign wr_slot  = i_start_new ? '0 : r_rp;
    assign n_rp     = (int'(wr_slot) == WINDOW_MAX - 1) ? '0 : wr_slot + AW'(1);
    assign fill_inc = r_fill + CW'(1);
    assign idx_dec  = r_idx - CW'(1);
    assign med_idx  = (r_win - CW'(1)) >> 1;

    // The oldest held sample sits fill slots behind the write pointer.
    always_comb begin
        old_sum = SW'(r_rp) + SW'(WINDOW_MAX) - SW'(fill_inc);
        if (old_sum >= SW'(WINDOW_MAX)) begin
            old_idx = old_sum - SW'(WINDOW_MAX);
        end else begin
            old_idx = old_sum;
        end
    end

    assign rem_hit = (i_srt_rdata == r_old);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win       <= CW'(1);
            r_fill      <= '0;
            r_rp        <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_win  <= n_win;
                r_fill <= '0;
                r_rp   <= '0;
            end
            if (i_cmd.accept) begin
                r_rp  <= n_rp;
                r_idx <= i_start_new ? '0 : r_fill;
                if (i_start_new) begin
                    r_fill <= '0;
                end
            end
            if (i_cmd.ins_shift) begin
                r_idx <= idx_dec;
            end
            if (i_cmd.ins_done) begin
                r_fill <= fill_inc;
            end
            if (i_cmd.med_cap) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.rem_cmp) begin
                r_idx <= r_idx + CW'(1);
                if (!r_found && rem_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.rem_done && r_found) begin
                r_fill <= r_fill - CW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x <= $signed(i_sample);
        end
        if (i_cmd.med_cap) begin
            r_med <= i_srt_rdata;
            r_old <= i_ring_rdata;
        end
        if (i_cmd.out_load) begin
            r_median <= r_med;
        end
    end

    // Sorted memory ports.
    always_comb begin
        o_srt_we    = 1'b0;
        o_srt_waddr = r_idx[AW-1:0];
        o_srt_wdata = i_srt_rdata;
        if (i_cmd.ins_shift) begin
            o_srt_we = 1'b1;
        end else if (i_cmd.ins_put) begin
            o_srt_we    = 1'b1;
            o_srt_wdata = r_x;
        end else if (i_cmd.rem_cmp && r_found) begin
            o_srt_we    = 1'b1;
            o_srt_waddr = idx_dec[AW-1:0];
        end
    end

    always_comb begin
        if (i_cmd.ins_rd) begin
            o_srt_raddr = idx_dec[AW-1:0];
        end else if (i_cmd.med_rd) begin
            o_srt_raddr = med_idx[AW-1:0];
        end else begin
            o_srt_raddr = r_idx[AW-1:0];
        end
    end

    assign o_ring_we    = i_cmd.accept;
    assign o_ring_waddr = wr_slot;
    assign o_ring_wdata = i_sample;
    assign o_ring_raddr = old_idx[AW-1:0];

    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.gt       = ($signed(i_srt_rdata) > r_x);
    assign o_sts.full     = (fill_inc >= r_win);
    assign o_sts.rem_end  = (r_idx == r_fill);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid  = r_out_valid;
    assign o_median = r_median;

endmodule

// File: hw/rtl/swm_ctrl.sv
// ----------------------------------------------------------------------------
// swm_ctrl: controller of the sliding window median filter
// Sequences insertion, median read and removal over the sorted memory.
// ----------------------------------------------------------------------------
module swm_ctrl
    import swm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic i_cfg_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall,
    output logic o_cfg_ready
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_INS_CHK = 3'd1;
    localparam logic [2:0] S_INS_CMP = 3'd2;
    localparam logic [2:0] S_INS_END = 3'd3;
    localparam logic [2:0] S_MED     = 3'd4;
    localparam logic [2:0] S_MED_OUT = 3'd5;
    localparam logic [2:0] S_REM_CHK = 3'd6;
    localparam logic [2:0] S_REM_CMP = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                // A waiting sample request goes first; the size write follows.
                o_cmd.cfg_wr = i_cfg_valid && !i_valid;
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                if (i_sts.idx_zero) begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = S_INS_END;
                end else begin
                    o_cmd.ins_rd = 1'b1;
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts.gt) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_CHK;
                end else begin
                    o_cmd.ins_put = 1'b1;
                    n_state       = S_INS_END;
                end
            end
            S_INS_END: begin
                o_cmd.ins_done = 1'b1;
                if (i_sts.full) begin
                    o_cmd.med_rd = 1'b1;
                    n_state      = S_MED;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MED: begin
                o_cmd.med_cap = 1'b1;
                n_state       = S_MED_OUT;
            end
            S_MED_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_REM_CHK;
                end
            end
            S_REM_CHK: begin
                if (i_sts.rem_end) begin
                    o_cmd.rem_done = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.rem_rd = 1'b1;
                    n_state      = S_REM_CMP;
                end
            end
            S_REM_CMP: begin
                o_cmd.rem_cmp = 1'b1;
                n_state       = S_REM_CHK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_valid;

endmodule

// File: hw/rtl/sliding_window_median.sv
// Results: none while the window fills; with a full window the median is
// valid once insertion, median read and output load are done, plus output stalls.
// Throughput: one request at a time; the next is taken once the insertion scan
// ends while filling, and once the removal scan ends with a full window.
// The single write port and single read port of the sorted memory set this.
// Reset: synchronous, active low; window empty, window size 1, output empty.
// ----------------------------------------------------------------------------
// sliding_window_median: lower median over a sliding window of samples
// Keeps samples in arrival order and in a sorted memory; emits the lower
// median each time the window is full, then drops the oldest sample.
// ----------------------------------------------------------------------------
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_start_new,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_median,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_W-1:0]    i_cfg_data
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    t_cmd                cmd;
    t_sts                sts;
    logic                srt_we;
    logic [AW-1:0]       srt_waddr;
    logic [SAMPLE_W-1:0] srt_wdata;
    logic [AW-1:0]       srt_raddr;
    logic [SAMPLE_W-1:0] srt_rdata;
    logic                ring_we;
    logic [AW-1:0]       ring_waddr;
    logic [SAMPLE_W-1:0] ring_wdata;
    logic [AW-1:0]       ring_raddr;
    logic [SAMPLE_W-1:0] ring_rdata;

    swm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_stall     (o_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    swm_dp #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_sample     (i_sample),
        .i_start_new  (i_start_new),
        .i_cfg_data   (i_cfg_data),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_median     (o_median),
        .o_srt_we     (srt_we),
        .o_srt_waddr  (srt_waddr),
        .o_srt_wdata  (srt_wdata),
        .o_srt_raddr  (srt_raddr),
        .i_srt_rdata  (srt_rdata),
        .o_ring_we    (ring_we),
        .o_ring_waddr (ring_waddr),
        .o_ring_wdata (ring_wdata),
        .o_ring_raddr (ring_raddr),
        .i_ring_rdata (ring_rdata)
    );

    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_sorted_ram (
        .i_clk   (i_clk),
        .i_we    (srt_we),
        .i_waddr (srt_waddr),
        .i_wdata (srt_wdata),
        .i_raddr (srt_raddr),
        .o_rdata (srt_rdata)
    );

    swm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_MAX)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

`ifndef ASSERT_OFF
    a_one_sorted_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.ins_rd, cmd.med_rd, cmd.rem_rd}))
        else $error("more than one sorted memory read issued");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output register overwritten while a result waits");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !cmd.out_load)
        else $error("result loaded before insertion finished");

    a_cfg_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cfg_wr |-> !o_stall && !cmd.ins_done && !cmd.rem_cmp)
        else $error("window size written while a request is in work");
`endif

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sliding window median filter
// Feeds directed and random sample streams under several window sizes, with
// random gaps on the input and random stalls on the output, and checks each
// median against a queue-based model of the window kept in this bench.
// ----------------------------------------------------------------------------
module tb;
    import swm_pkg::*;

    localparam int WIN_CAP      = 64;
    localparam int RAND_ITEMS   = 850;
    localparam int QUIET_AFTER  = 760;
    // A full window of the largest size needs an insertion and a removal scan per request.
    localparam int SETTLE       = 4 * WIN_CAP + 40;
    localparam int DRAIN_GUARD  = 50000;
    localparam int N_ROWS       = 31;

    typedef enum logic [0:0] {ROW_SAMPLE, ROW_WINDOW} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;
        logic        start_new;
        logic        typed;
        logic [31:0] median;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic                i_start_new = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [SAMPLE_W-1:0] o_median;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    // Window state as this bench sees it.
    logic [CFG_W-1:0] win_reg = 7'd1;
    t_sample          in_order[$];
    t_sample          by_value[$];
    t_sample          medians_due[$];

    int  err_count  = 0;
    int  n_items    = 0;
    int  n_medians  = 0;
    int  n_windows  = 0;
    bit  quiet      = 1'b0;
    int  burst_left = 0;

    // Typed medians apply only where the value is plain: window of one, and
    // a zero window size that acts as one.
    t_plan_row plan [0:N_ROWS-1] = '{
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000},
        '{ROW_SAMPLE, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF},
        '{ROW_WINDOW, 32'd0,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005},
        '{ROW_WINDOW, 32'd4,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd10,        1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd10,        1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd7,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd10,        1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd2,         1'b1, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd3,         1'b0, 1'b0, 32'h0},
        '{ROW_WINDOW, 32'd3,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd1,         1'b0, 1'b0, 32'h0},
        '{ROW_WINDOW, 32'd127,       1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'h8000_0000, 1'b1, 1'b0, 32'h0},
        '{ROW_WINDOW, 32'd65,        1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd4,         1'b0, 1'b0, 32'h0},
        '{ROW_WINDOW, 32'd2,         1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd100,       1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'hFFFF_FF9C, 1'b0, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd50,        1'b1, 1'b0, 32'h0},
        '{ROW_SAMPLE, 32'd60,        1'b0, 1'b0, 32'h0},
        '{ROW_WINDOW, 32'd1,         1'b0, 1'b0, 32'h0}
    };

    sliding_window_median #(
        .WINDOW_MAX (WIN_CAP)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_start_new (i_start_new),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_median    (o_median),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int window_len(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > WIN_CAP) return WIN_CAP;
        return int'(v);
    endfunction

    // Inserts one sample into the window; returns 1 with the lower median
    // once the window is full, after which the oldest sample is dropped.
    function automatic bit slide_window(input t_sample x, input logic start_new,
                                        output t_sample med);
        int      pos;
        int      win;
        t_sample oldest;
        win = window_len(win_reg);
        med = '0;
        if (start_new) begin
            in_order.delete();
            by_value.delete();
        end
        in_order.push_back(x);
        pos = 0;
        while (pos < by_value.size() && by_value[pos] <= x) pos++;
        by_value.insert(pos, x);
        if (by_value.size() < win) return 1'b0;
        med = by_value[(win - 1) / 2];
        // Only one copy of a repeated value leaves the window.
        oldest = in_order.pop_front();
        pos = 0;
        while (pos < by_value.size() && by_value[pos] != oldest) pos++;
        if (pos < by_value.size()) by_value.delete(pos);
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance
    // with i_valid still high.
    task automatic send_sample(input logic [31:0] s, input logic sn,
                               input logic typed, input logic [31:0] typed_med);
        t_sample med;
        bit      got;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= s;
        i_start_new <= sn;
        do @(posedge i_clk); while (o_stall);
        got = slide_window(t_sample'(s), sn, med);
        if (typed && got) med = t_sample'(typed_med);
        if (got) medians_due.push_back(med);
        n_items++;
        @(negedge i_clk);
    endtask

    // Lets every due median arrive, then lets the block finish any removal
    // or insertion that has no result of its own.
    task automatic wait_for_medians();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (medians_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        if (medians_due.size() != 0) begin
            flag_mismatch($sformatf("%0d medians never arrived", medians_due.size()));
            medians_due.delete();
        end
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] v);
        wait_for_medians();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        win_reg = v;
        in_order.delete();
        by_value.delete();
        n_windows++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Output side: random stall bursts, none once the run goes quiet.
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_stall    <= 1'b0;
            burst_left <= 0;
        end else if (burst_left != 0) begin
            i_stall    <= 1'b1;
            burst_left <= burst_left - 1;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 7) == 0) burst_left <= $urandom_range(1, 11);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (medians_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected median %0d", $signed(o_median)));
            end else begin
                if (o_median !== medians_due[0])
                    flag_mismatch($sformatf("median %0d, expected %0d",
                                            $signed(o_median), medians_due[0]));
                void'(medians_due.pop_front());
                n_medians++;
            end
        end
    end

    initial begin
        int               r;
        int               k;
        int               phase;
        int               run_len;
        int               rand_sent;
        logic [CFG_W-1:0] wv;
        logic [31:0]      s;
        logic             sn;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            if (plan[r].kind == ROW_WINDOW)
                write_window(plan[r].value[CFG_W-1:0]);
            else
                send_sample(plan[r].value, plan[r].start_new, plan[r].typed,
                            plan[r].median);
        end

        // Random phases: the size extremes first, then mostly small windows
        // so that many full windows are reached.
        rand_sent = 0;
        phase = 0;
        while (rand_sent < RAND_ITEMS) begin
            case (phase)
                0:       wv = 7'd127;
                1:       wv = 7'd0;
                2:       wv = 7'd64;
                3:       wv = 7'd65;
                default: wv = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(1, 10));
            endcase
            write_window(wv);
            run_len = (window_len(wv) > 16) ? 140 : 60;
            for (k = 0; k < run_len && rand_sent < RAND_ITEMS; k++) begin
                quiet = (rand_sent >= QUIET_AFTER);
                case ($urandom_range(0, 9))
                    0:       s = 32'h7FFF_FFFF;
                    1:       s = 32'h8000_0000;
                    2, 3, 4: s = $urandom_range(0, 8) - 4;
                    default: s = $urandom;
                endcase
                sn = ($urandom_range(0, 39) == 0);
                send_sample(s, sn, 1'b0, 32'h0);
                rand_sent++;
            end
            phase++;
        end

        wait_for_medians();
        $display("tb: %0d samples sent under %0d window settings, %0d medians checked",
                 n_items, n_windows, n_medians);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(20 * 4_000_000);
        $display("tb: failure");
        $finish;
    end

endmodule
